// File: src/fcd_pkg.sv
// ============================================================================
// fcd_pkg
// Shared constants, widths and types of the frame change detector.
// ============================================================================
`default_nettype none

package fcd_pkg;

  // largest frame in bytes, one bank of the frame store holds one frame
  localparam int MAX_FRAME = 65536;

  // field widths
  localparam int PIX_W  = 8;
  localparam int SENS_W = 17;
  localparam int SIZE_W = 17;
  localparam int CHG_W  = 17;
  localparam int SHOT_W = 24;

  // derived widths
  localparam int POS_W   = $clog2(MAX_FRAME);
  localparam int CNT_W   = $clog2(MAX_FRAME + 1);
  localparam int ADDR_W  = POS_W + 1;
  localparam int DEPTH   = 2 * MAX_FRAME;
  localparam int PROD_W  = SENS_W + CNT_W;
  localparam int FRAC_W  = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSITIVITY = 1'b0,
    CFG_FRAME_SIZE  = 1'b1
  } cfg_idx_t;

  // reset values
  localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(655);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);
  localparam logic [SHOT_W-1:0] SHOT_RESET = SHOT_W'(1);
  localparam logic [SHOT_W-1:0] SHOT_MAX   = {SHOT_W{1'b1}};

  // one result item
  typedef struct packed {
    logic              kept;
    logic [CHG_W-1:0]  changed_count;
    logic [SHOT_W-1:0] shot_number;
  } fcd_result_t;

  // frame size as used: zero acts as one, oversize clamps to the frame limit
  function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [CNT_W-1:0] r;
    if (s == '0) begin
      r = CNT_W'(1);
    end else if (32'(s) > 32'(MAX_FRAME)) begin
      r = CNT_W'(MAX_FRAME);
    end else begin
      r = CNT_W'(s);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/fcd_in_if.sv
// ============================================================================
// fcd_in_if
// Valid/ready channel carrying one frame byte per item.
// ============================================================================
`default_nettype none

interface fcd_in_if;
  import fcd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

`default_nettype wire

// File: src/fcd_out_if.sv
// ============================================================================
// fcd_out_if
// Valid/ready channel carrying one per-frame result item.
// ============================================================================
`default_nettype none

interface fcd_out_if;
  import fcd_pkg::*;

  logic              valid;
  logic              ready;
  logic              kept;
  logic [CHG_W-1:0]  changed_count;
  logic [SHOT_W-1:0] shot_number;

  modport source (output valid, output kept, output changed_count, output shot_number,
                  input ready);
  modport sink   (input valid, input kept, input changed_count, input shot_number,
                  output ready);
endinterface

`default_nettype wire

// File: src/frame_change_detector.sv
// ============================================================================
// frame_change_detector
// Frame-difference change detector: stores each frame byte in the free bank,
// counts bytes unequal to the reference bank and decides per frame whether
// the frame becomes the new reference.
// ============================================================================
//
//  channel   dir  handshake      payload
//  --------  ---  -------------  --------------------------------------------
//  in_ch     in   valid/ready    pixel_byte[7:0]
//  out_ch    out  valid/ready    kept, changed_count[16:0], shot_number[23:0]
//  cfg_*     in   cfg_we only    cfg_index (0 sensitivity, 1 frame_size),
//                                cfg_data[16:0]
//
//  one byte per clock unless input stalls; each byte is written to and its
//  reference byte read from the two-bank store at the accept edge, compared
//  in the next cycle. the keep decision of a frame's last byte steers the
//  bank of the very next byte, so frames follow each other without a gap.
//  a result sits in an output register with one skid entry behind it; input
//  stalls only while both would be full.
//  reset clears control state only; the frame store needs no clearing pass.
//
`default_nettype none

module frame_change_detector (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  fcd_in_if.sink                              in_ch,
  fcd_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [fcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fcd_pkg::*;

  // configuration
  logic [SENS_W-1:0] sens_r;
  logic [SIZE_W-1:0] size_r;
  logic [CNT_W-1:0]  size_eff;
  logic [PROD_W-1:0] prod_r;

  // frame state
  logic              bank_r;
  logic              bank_cur;
  logic              has_ref_r;
  logic              has_ref_cur;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic [CNT_W-1:0]  diff_r;
  logic [CNT_W-1:0]  diff_nxt;
  logic [SHOT_W-1:0] shot_r;

  // compare stage
  logic              b_valid_r;
  logic              b_last_r;
  logic [PIX_W-1:0]  b_px_r;
  logic [PIX_W-1:0]  rd_data;
  logic              mism;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  diff_inc;
  logic              ge0;
  logic              ge1;
  logic              keep;
  logic              res_valid;
  fcd_result_t       res;

  // output register and skid
  logic              out_valid_r;
  fcd_result_t       out_r;
  logic              skid_valid_r;
  fcd_result_t       skid_r;
  logic              out_free;

  logic              accept;
  logic              last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= SENS_RESET;
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SENSITIVITY: sens_r <= SENS_W'(cfg_data);
        CFG_FRAME_SIZE:  size_r <= SIZE_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign size_eff = eff_size(size_r);

  // threshold product sensitivity * size, refreshed every cycle
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(sens_r) * PROD_W'(size_eff);
  end

  // input handshake: stall while the skid is full or a result has no room
  assign in_ch.ready = !skid_valid_r &&
                       !(b_valid_r && b_last_r && out_valid_r && !out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;

  // position within the frame
  assign last    = (32'(pos_r) + 32'd1) >= 32'(size_eff);
  assign pos_nxt = last ? '0 : pos_r + POS_W'(1);

  // keep decision of the byte in the compare stage
  assign mism     = has_ref_r && (rd_data != b_px_r);
  assign diff_inc = diff_r + CNT_W'(1);
  assign count    = mism ? diff_inc : diff_r;
  assign ge0      = (PROD_W'(diff_r) << FRAC_W) >= prod_r;
  assign ge1      = (PROD_W'(diff_inc) << FRAC_W) >= prod_r;
  assign keep     = !has_ref_r || (mism ? ge1 : ge0);
  assign res_valid = b_valid_r && b_last_r;

  // bank and reference flag as seen by the byte accepted now
  assign bank_cur    = bank_r ^ (res_valid && keep);
  assign has_ref_cur = has_ref_r || res_valid;

  assign diff_nxt = (b_valid_r && !b_last_r) ? count :
                    (res_valid ? '0 : diff_r);

  always_comb begin
    res.kept          = keep;
    res.changed_count = has_ref_r ? CHG_W'(count) : '0;
    res.shot_number   = shot_r;
  end

  // frame store: current byte into the free bank, reference byte out
  fcd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr ({~bank_cur, pos_r}),
    .wdata (in_ch.pixel_byte),
    .re    (accept),
    .raddr ({bank_cur, pos_r}),
    .rdata (rd_data)
  );

  // frame control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r    <= 1'b0;
      has_ref_r <= 1'b0;
      pos_r     <= '0;
      diff_r    <= '0;
      shot_r    <= SHOT_RESET;
      b_valid_r <= 1'b0;
    end else begin
      bank_r    <= bank_cur;
      has_ref_r <= has_ref_cur;
      diff_r    <= diff_nxt;
      b_valid_r <= accept;
      if (accept) begin
        pos_r <= pos_nxt;
      end
      if (res_valid && keep && shot_r != SHOT_MAX) begin
        shot_r <= shot_r + SHOT_W'(1);
      end
    end
  end

  // compare stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      b_px_r   <= in_ch.pixel_byte;
      b_last_r <= last;
    end
  end

  // output register with one skid entry
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= skid_valid_r || res_valid;
      end
      if (out_free) begin
        skid_valid_r <= skid_valid_r && res_valid;
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (res_valid && (!out_free || skid_valid_r)) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kept          = out_r.kept;
  assign out_ch.changed_count = out_r.changed_count;
  assign out_ch.shot_number   = out_r.shot_number;

endmodule

`default_nettype wire

// File: src/fcd_ram.sv
// ============================================================================
// fcd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module fcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: verif/frame_change_detector_tb.sv
// ============================================================================
// frame_change_detector_tb
// Self-checking bench for the frame change detector. Frame bytes stream in on
// the pixel channel. A local model of the two-bank frame store, the changed
// byte count and the keep rule predicts each per-frame verdict. Verdicts are
// compared field by field in arrival order. The run covers sensitivity edge
// values, zero frame size and mid-frame size changes. Both channels get
// random idle cycles, and there is one long output hold-off.
// ============================================================================
`default_nettype none

module frame_change_detector_tb;
  import fcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 7;
  localparam int RANDOM_ITEMS  = 1000;
  // longest frame used, both banks are primed up to this length
  localparam int PRIME_LEN     = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fcd_in_if  pix_ch ();
  fcd_out_if res_ch ();

  frame_change_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // stimulus and expectation stores
  logic [PIX_W-1:0] bytes_to_send [$];
  fcd_result_t      pending_verdicts [$];
  int               mismatch_count;
  bit               calm;
  logic             hold_request;
  logic             hold_taken;
  int               hold_left;
  logic [PIX_W-1:0] phase_pattern [64];

  // local copy of the detector state
  logic [SENS_W-1:0] sens_now;
  logic [SIZE_W-1:0] size_now;
  logic [PIX_W-1:0]  frame_mem [2][MAX_FRAME];
  logic              ref_bank;
  logic              have_ref;
  int                byte_pos;
  logic [CNT_W-1:0]  diff_bytes;
  logic [SHOT_W-1:0] next_shot;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #3000000;
    $display("** frame_change_detector: FAILED **");
    $finish;
  end

  // one byte into the detector model, queues a verdict at a frame's end
  function automatic void take_pixel(input logic [PIX_W-1:0] px);
    int          span;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic        keep;
    fcd_result_t verdict;
    if (size_now == '0) begin
      span = 1;
    end else if (int'(size_now) > MAX_FRAME) begin
      span = MAX_FRAME;
    end else begin
      span = int'(size_now);
    end
    if (have_ref && frame_mem[ref_bank][byte_pos] != px) begin
      diff_bytes = diff_bytes + CNT_W'(1);
    end
    frame_mem[!ref_bank][byte_pos] = px;
    if (byte_pos + 1 < span) begin
      byte_pos = byte_pos + 1;
      return;
    end
    lhs  = 64'(diff_bytes) << 16;
    rhs  = 64'(sens_now) * 64'(span);
    keep = !have_ref || (lhs >= rhs);
    verdict.kept          = keep;
    verdict.changed_count = have_ref ? CHG_W'(diff_bytes) : '0;
    verdict.shot_number   = next_shot;
    pending_verdicts.insert(pending_verdicts.size(), verdict);
    if (keep) begin
      ref_bank = !ref_bank;
      have_ref = 1'b1;
      if (next_shot != SHOT_MAX) begin
        next_shot = next_shot + SHOT_W'(1);
      end
    end
    byte_pos   = 0;
    diff_bytes = '0;
  endfunction

  // pixel driver, also tracks register writes and accepted bytes
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid      <= 1'b0;
      pix_ch.pixel_byte <= '0;
      sens_now   = SENS_RESET;
      size_now   = SIZE_RESET;
      ref_bank   = 1'b0;
      have_ref   = 1'b0;
      byte_pos   = 0;
      diff_bytes = '0;
      next_shot  = SHOT_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SENSITIVITY) begin
          sens_now = SENS_W'(cfg_data);
        end else begin
          size_now = SIZE_W'(cfg_data);
        end
      end
      if (pix_ch.valid && pix_ch.ready) begin
        take_pixel(pix_ch.pixel_byte);
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (bytes_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          pix_ch.valid      <= 1'b1;
          pix_ch.pixel_byte <= bytes_to_send.pop_front();
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with random idles and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_taken   <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_taken   <= 1'b1;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // verdict checker
  always @(posedge clk) begin
    fcd_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected verdict: kept %0d changed_count %0d shot_number %0d",
               res_ch.kept, res_ch.changed_count, res_ch.shot_number);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_verdicts.pop_front();
        if (res_ch.kept !== want.kept) begin
          $error("kept: expected %0d, got %0d", want.kept, res_ch.kept);
          mismatch_count = mismatch_count + 1;
        end
        if (res_ch.changed_count !== want.changed_count) begin
          $error("changed_count: expected %0d, got %0d",
                 want.changed_count, res_ch.changed_count);
          mismatch_count = mismatch_count + 1;
        end
        if (res_ch.shot_number !== want.shot_number) begin
          $error("shot_number: expected %0d, got %0d",
                 want.shot_number, res_ch.shot_number);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // register write while the detector is idle
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // wait until every byte is taken and every verdict checked, then let
  // the compare pipeline drain
  task automatic settle();
    while (bytes_to_send.size() != 0 || pix_ch.valid || pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // append one byte to the stimulus queue
  task automatic queue_byte(input logic [PIX_W-1:0] b);
    bytes_to_send.insert(bytes_to_send.size(), b);
  endtask

  task automatic send4(input logic [7:0] a, input logic [7:0] b,
                       input logic [7:0] c, input logic [7:0] d);
    queue_byte(a);
    queue_byte(b);
    queue_byte(c);
    queue_byte(d);
  endtask

  // one frame from the phase pattern, each byte altered with some chance
  task automatic queue_frame(input int len, input int flip_pct);
    logic [7:0] b;
    for (int k = 0; k < len; k++) begin
      b = phase_pattern[k];
      if ($urandom_range(0, 99) < flip_pct) begin
        b = b ^ 8'($urandom_range(1, 255));
      end
      queue_byte(b);
    end
  endtask

  // stimulus sequence
  initial begin
    int          phase;
    int          sent;
    int          span;
    int          frames;
    int          pct;
    int          extra;
    logic [16:0] sens_val;
    logic [16:0] size_val;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_SENSITIVITY;
    cfg_data          = '0;
    pix_ch.valid      = 1'b0;
    pix_ch.pixel_byte = '0;
    res_ch.ready      = 1'b0;
    hold_request      = 1'b0;
    calm              = 1'b0;
    mismatch_count    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // prime both banks up to the longest frame used later
    write_reg(CFG_FRAME_SIZE, 17'(PRIME_LEN));
    write_reg(CFG_SENSITIVITY, 17'd0);
    for (int k = 0; k < 2 * PRIME_LEN; k++) begin
      queue_byte(8'($urandom_range(0, 255)));
    end
    settle();
    write_reg(CFG_SENSITIVITY, 17'd65536);
    // every byte differs, count hits the full frame at the keep threshold
    for (int k = 0; k < PRIME_LEN; k++) begin
      queue_byte(frame_mem[ref_bank][k] ^ 8'($urandom_range(1, 255)));
    end
    settle();

    // small frames, force a known reference
    write_reg(CFG_FRAME_SIZE, 17'd4);
    write_reg(CFG_SENSITIVITY, 17'd0);
    send4(8'h00, 8'hFF, 8'h55, 8'hAA);
    settle();
    write_reg(CFG_SENSITIVITY, 17'd655);
    send4(8'hFF, 8'h00, 8'hAA, 8'h55);
    settle();
    // full-scale sensitivity: all changed keeps, one changed drops
    write_reg(CFG_SENSITIVITY, 17'd65536);
    send4(8'h00, 8'hFF, 8'h55, 8'hAA);
    send4(8'h00, 8'hFF, 8'h55, 8'h55);
    settle();
    // sensitivity above full scale always drops
    write_reg(CFG_SENSITIVITY, 17'h1FFFF);
    send4(8'hFF, 8'h00, 8'hAA, 8'h55);
    settle();
    // zero frame size acts as one byte
    write_reg(CFG_FRAME_SIZE, 17'd0);
    write_reg(CFG_SENSITIVITY, 17'd0);
    queue_byte(8'h00);
    settle();
    // shrink mid-frame: the frame ends on the next byte
    write_reg(CFG_FRAME_SIZE, 17'd4);
    write_reg(CFG_SENSITIVITY, 17'd32768);
    queue_byte(8'h12);
    queue_byte(8'h34);
    settle();
    write_reg(CFG_FRAME_SIZE, 17'd2);
    queue_byte(8'h56);
    settle();
    // grow mid-frame
    queue_byte(8'h9A);
    settle();
    write_reg(CFG_FRAME_SIZE, 17'd4);
    queue_byte(8'hBC);
    queue_byte(8'hDE);
    queue_byte(8'hF0);
    settle();

    // random phases, some ending mid-frame; the hold-off phase always runs
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS || phase <= 4) begin
      case ($urandom_range(0, 9))
        0:       span = 1;
        1, 2:    span = $urandom_range(9, PRIME_LEN);
        default: span = $urandom_range(1, 8);
      endcase
      if (phase == 4) begin
        span = 1;
      end
      size_val = (span == 1 && $urandom_range(0, 1) == 1) ? 17'd0 : 17'(span);
      case ($urandom_range(0, 5))
        0:       sens_val = 17'd0;
        1:       sens_val = 17'd65536;
        2:       sens_val = 17'($urandom_range(65537, 131071));
        3, 4:    sens_val = 17'(($urandom_range(0, span) * 65536) / span);
        default: sens_val = 17'($urandom_range(0, 65536));
      endcase
      if (phase == 0 || $urandom_range(0, 9) < 7) begin
        write_reg(CFG_FRAME_SIZE, size_val);
      end
      if (phase == 0 || $urandom_range(0, 9) < 7) begin
        write_reg(CFG_SENSITIVITY, sens_val);
      end
      if (int'(size_now) != span && !(size_now == '0 && span == 1)) begin
        write_reg(CFG_FRAME_SIZE, size_val);
      end
      for (int k = 0; k < 64; k++) begin
        phase_pattern[k] = 8'($urandom_range(0, 255));
      end
      calm   = (phase == 2);
      frames = calm ? 20 : $urandom_range(2, 8);
      if (phase == 4) begin
        // long output hold while single-byte frames keep coming
        frames = 80;
        @(posedge clk);
        hold_request <= 1'b1;
      end
      for (int f = 0; f < frames; f++) begin
        case ($urandom_range(0, 4))
          0:       pct = 0;
          1:       pct = 5;
          2:       pct = 30;
          3:       pct = 100;
          default: pct = $urandom_range(0, 100);
        endcase
        queue_frame(span, pct);
      end
      extra = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span - 1) : 0;
      queue_frame(extra, 50);
      sent = sent + frames * span + extra;
      settle();
      calm  = 1'b0;
      phase = phase + 1;
    end

    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("** frame_change_detector: PASSED **");
    end else begin
      $display("** frame_change_detector: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
